>>> rtl/core/clnb_pkg.sv
// clnb_pkg: shared types, constants and helper functions for the cell list
// neighbor bin enumerator. No dependencies.
`timescale 1ns / 1ps

package clnb_pkg;

    localparam int MAX_BINS_PER_AXIS = 64;
    localparam int NB_W       = 7;                                  // axis size register
    localparam int CRD_W      = $clog2(MAX_BINS_PER_AXIS);          // one coordinate
    localparam int PLANE_W    = $clog2(MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS + 1);
    localparam int TOTAL_W    = $clog2(MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS
                                       * MAX_BINS_PER_AXIS + 1);
    localparam int IDX_W      = 18;
    localparam int MASK_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int NOFF       = 3;                                  // offers per axis
    localparam int OCNT_W     = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BINS_X   = 2'd0,
        CFG_BINS_Y   = 2'd1,
        CFG_BINS_Z   = 2'd2,
        CFG_PERIODIC = 2'd3
    } t_cfg_reg;

    typedef logic [CRD_W-1:0] t_crd;
    typedef logic [NB_W-1:0]  t_nb;

    typedef struct packed {
        t_nb               bins_x;
        t_nb               bins_y;
        t_nb               bins_z;
        logic [MASK_W-1:0] periodic;
    } t_cfg;

    // One decoded cell handed from front to back.
    typedef struct packed {
        logic               bad;
        t_crd               x;
        t_crd               y;
        t_crd               z;
        logic [PLANE_W-1:0] plane;
    } t_qent;

    // Coordinates offered along one axis, packed from slot 0.
    typedef struct packed {
        t_crd [NOFF-1:0]   crd;
        logic [OCNT_W-1:0] cnt;
    } t_offers;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PLANE,
        F_TOTAL,
        F_CHECK,
        F_DIVX,
        F_DIVY,
        F_PUSH
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } t_bstate;

    function automatic t_nb axis_size(input t_nb v);
        return (v > NB_W'(MAX_BINS_PER_AXIS)) ? NB_W'(MAX_BINS_PER_AXIS) : v;
    endfunction

    // Self, then +1, then -1; wrap only on a periodic axis of more than two cells.
    function automatic t_offers axis_offers(input t_crd c, input t_nb n, input logic wraps);
        t_offers o;
        logic    may_wrap;
        t_nb     c_up;
        t_nb     n_dn;
        o        = '0;
        may_wrap = wraps && (n > NB_W'(2));
        c_up     = NB_W'(c) + NB_W'(1);
        n_dn     = n - NB_W'(1);
        o.crd[0] = c;
        o.cnt    = OCNT_W'(1);
        if (c_up < n) begin
            o.crd[o.cnt] = c_up[CRD_W-1:0];
            o.cnt        = o.cnt + OCNT_W'(1);
        end else if (may_wrap) begin
            o.crd[o.cnt] = '0;
            o.cnt        = o.cnt + OCNT_W'(1);
        end
        if (c != '0) begin
            o.crd[o.cnt] = c - CRD_W'(1);
            o.cnt        = o.cnt + OCNT_W'(1);
        end else if (may_wrap) begin
            o.crd[o.cnt] = n_dn[CRD_W-1:0];
            o.cnt        = o.cnt + OCNT_W'(1);
        end
        return o;
    endfunction

endpackage

>>> rtl/core/cell_list_neighbor_bins.sv
// cell_list_neighbor_bins: top level of the 3D cell list neighbor enumerator.
// Depends on clnb_pkg, clnb_front, clnb_fifo and clnb_back.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ---------------------------------------
//  input    in         i_valid / o_ready   i_cell_index[17:0]
//  output   out        o_valid / i_ready   o_neighbor_index[17:0], o_last, o_bad_index
//  config   in         i_cfg_we            i_cfg_idx[1:0], i_cfg_data[6:0]
//
//  Steps: the front decodes one cell at a time (two multiplies for plane and
//  grid total, a range check, two restoring divisions, a push).
//  The back emits one neighbor per cycle while the output is not stalled, after
//  loading the cell from the queue, so a cell with N neighbors (N up to 27) is
//  one load plus N transfers there; the sustained rate is the slower of the two.
//  An out-of-range index skips the division and gives a single transfer.
//  Reset (synchronous, active low) empties the queue, idles both halves and
//  loads bins 1/1/1, no wrapping. Output stalls back up through the queue
//  into o_ready; the front keeps decoding while the back waits.

module cell_list_neighbor_bins #(
    parameter int QUEUE_DEPTH = clnb_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clnb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [clnb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [clnb_pkg::IDX_W-1:0]        i_cell_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [clnb_pkg::IDX_W-1:0]        o_neighbor_index,
    output logic                              o_last,
    output logic                              o_bad_index
);

    import clnb_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_qent  push_entry;
    t_qent  head_entry;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;

    // Register file; the user must write only while no cell is in flight, the block does not enforce it.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_BINS_X:   n_cfg.bins_x   = i_cfg_data;
                CFG_BINS_Y:   n_cfg.bins_y   = i_cfg_data;
                CFG_BINS_Z:   n_cfg.bins_z   = i_cfg_data;
                CFG_PERIODIC: n_cfg.periodic = i_cfg_data[MASK_W-1:0];
                default:      n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{bins_x: NB_W'(1), bins_y: NB_W'(1), bins_z: NB_W'(1), periodic: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: accept, range check, split into coordinates.
    clnb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_index (i_cell_index),
        .o_push       (q_push),
        .o_entry      (push_entry),
        .i_full       (q_full)
    );

    // Decoded cells wait here so each half stalls on its own.
    clnb_fifo #(
        .WIDTH ($bits(t_qent)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (head_entry),
        .o_empty (q_empty)
    );

    // Back: neighbor walk, x outermost, z innermost.
    clnb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .i_entry          (head_entry),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_neighbor_index (o_neighbor_index),
        .o_last           (o_last),
        .o_bad_index      (o_bad_index)
    );

endmodule

>>> rtl/core/clnb_fifo.sv
// clnb_fifo: small register queue between front and back.
// Depends on nothing; width and depth come in as parameters (depth >= 2).
`timescale 1ns / 1ps

module clnb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> rtl/core/clnb_front.sv
// clnb_front: accepts a flat cell index, range checks it and splits it into
// x, y, z with a shared restoring divider. Depends on clnb_pkg.
`timescale 1ns / 1ps

module clnb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  clnb_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [clnb_pkg::IDX_W-1:0]   i_cell_index,
    output logic                         o_push,
    output clnb_pkg::t_qent              o_entry,
    input  logic                         i_full
);

    import clnb_pkg::*;

    localparam int STEP_W = $clog2(CRD_W + 1);

    t_fstate              r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [PLANE_W-1:0]   r_plane, n_plane;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [IDX_W-1:0]     r_rem, n_rem;
    logic [IDX_W-1:0]     r_div, n_div;
    t_crd                 r_q, n_q;
    logic [STEP_W-1:0]    r_cnt, n_cnt;
    t_crd                 r_x, n_x;
    t_crd                 r_y, n_y;
    t_crd                 r_z, n_z;
    logic                 r_bad, n_bad;

    t_nb                  nx, ny, nz;
    logic [2*NB_W-1:0]    plane_full;
    logic [NB_W+PLANE_W-1:0] total_full;
    logic                 beyond;
    logic                 ge;
    logic [IDX_W-1:0]     rem_step;
    t_crd                 q_step;
    logic                 div_done;

    assign nx         = axis_size(i_cfg.bins_x);
    assign ny         = axis_size(i_cfg.bins_y);
    assign nz         = axis_size(i_cfg.bins_z);
    assign plane_full = (2*NB_W)'(ny) * (2*NB_W)'(nz);
    assign total_full = (NB_W+PLANE_W)'(nx) * (NB_W+PLANE_W)'(r_plane);
    assign beyond     = ({1'b0, r_idx} >= TOTAL_W'(r_total));

    // one quotient bit per cycle
    assign ge       = (r_rem >= r_div);
    assign rem_step = ge ? (r_rem - r_div) : r_rem;
    assign q_step   = {r_q[CRD_W-2:0], ge};
    assign div_done = (r_cnt == STEP_W'(CRD_W - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  begin if (i_valid) n_state = F_PLANE; end
            F_PLANE: begin n_state = F_TOTAL; end
            F_TOTAL: begin n_state = F_CHECK; end
            F_CHECK: begin n_state = beyond ? F_PUSH : F_DIVX; end
            F_DIVX:  begin if (div_done) n_state = F_DIVY; end
            F_DIVY:  begin if (div_done) n_state = F_PUSH; end
            F_PUSH:  begin if (!i_full) n_state = F_IDLE; end
            default: begin n_state = F_IDLE; end
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_PUSH) && !i_full;
        o_entry = '{bad: r_bad, x: r_x, y: r_y, z: r_z, plane: r_plane};
    end

    always_comb begin
        n_idx   = r_idx;
        n_plane = r_plane;
        n_total = r_total;
        n_rem   = r_rem;
        n_div   = r_div;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_bad   = r_bad;
        case (r_state)
            F_IDLE: begin
                if (i_valid) n_idx = i_cell_index;
            end
            F_PLANE: begin
                n_plane = plane_full[PLANE_W-1:0];
            end
            F_TOTAL: begin
                n_total = total_full[TOTAL_W-1:0];
            end
            F_CHECK: begin
                n_bad = beyond;
                n_rem = r_idx;
                n_div = IDX_W'(r_plane) << (CRD_W - 1);
                n_q   = '0;
                n_cnt = '0;
            end
            F_DIVX: begin
                n_rem = rem_step;
                n_q   = q_step;
                n_cnt = r_cnt + STEP_W'(1);
                n_div = r_div >> 1;
                if (div_done) begin
                    n_x   = q_step;
                    n_q   = '0;
                    n_cnt = '0;
                    n_div = IDX_W'(nz) << (CRD_W - 1);
                end
            end
            F_DIVY: begin
                n_rem = rem_step;
                n_q   = q_step;
                n_cnt = r_cnt + STEP_W'(1);
                n_div = r_div >> 1;
                if (div_done) begin
                    n_y = q_step;
                    n_z = rem_step[CRD_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_plane <= n_plane;
        r_total <= n_total;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_bad   <= n_bad;
    end

endmodule

>>> rtl/core/clnb_back.sv
// clnb_back: takes decoded cells from the queue and walks the x/y/z offer lists,
// one neighbor per unstalled cycle into an output register. Depends on clnb_pkg.
`timescale 1ns / 1ps

module clnb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  clnb_pkg::t_cfg               i_cfg,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  clnb_pkg::t_qent              i_entry,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [clnb_pkg::IDX_W-1:0]   o_neighbor_index,
    output logic                         o_last,
    output logic                         o_bad_index
);

    import clnb_pkg::*;

    t_bstate              r_state, n_state;
    t_offers              r_ox, n_ox;
    t_offers              r_oy, n_oy;
    t_offers              r_oz, n_oz;
    logic [PLANE_W-1:0]   r_plane, n_plane;
    t_nb                  r_nz, n_nz;
    logic                 r_bad, n_bad;
    logic [OCNT_W-1:0]    r_i, n_i;
    logic [OCNT_W-1:0]    r_j, n_j;
    logic [OCNT_W-1:0]    r_k, n_k;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_out_index, n_out_index;
    logic                 r_out_last, n_out_last;
    logic                 r_out_bad, n_out_bad;

    t_nb                  nx, ny, nz;
    t_offers              offx, offy, offz;
    logic                 emit;
    logic                 i_end, j_end, k_end;
    logic                 last_one;
    logic [CRD_W+PLANE_W-1:0] prod_x;
    logic [CRD_W+NB_W-1:0]    prod_y;
    logic [CRD_W+PLANE_W:0]   sum;

    assign nx   = axis_size(i_cfg.bins_x);
    assign ny   = axis_size(i_cfg.bins_y);
    assign nz   = axis_size(i_cfg.bins_z);
    assign offx = axis_offers(i_entry.x, nx, i_cfg.periodic[0]);
    assign offy = axis_offers(i_entry.y, ny, i_cfg.periodic[1]);
    assign offz = axis_offers(i_entry.z, nz, i_cfg.periodic[2]);

    assign i_end    = (r_i == r_ox.cnt - OCNT_W'(1));
    assign j_end    = (r_j == r_oy.cnt - OCNT_W'(1));
    assign k_end    = (r_k == r_oz.cnt - OCNT_W'(1));
    assign last_one = i_end && j_end && k_end;

    assign prod_x = (CRD_W+PLANE_W)'(r_ox.crd[r_i]) * (CRD_W+PLANE_W)'(r_plane);
    assign prod_y = (CRD_W+NB_W)'(r_oy.crd[r_j]) * (CRD_W+NB_W)'(r_nz);
    assign sum    = (CRD_W+PLANE_W+1)'(prod_x) + (CRD_W+PLANE_W+1)'(prod_y)
                  + (CRD_W+PLANE_W+1)'(r_oz.crd[r_k]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  begin if (!i_empty) n_state = B_RUN; end
            B_RUN:   begin if (emit && last_one) n_state = B_IDLE; end
            default: begin n_state = B_IDLE; end
        endcase
    end

    always_comb begin
        o_pop            = (r_state == B_IDLE) && !i_empty;
        emit             = (r_state == B_RUN) && (!r_out_valid || i_ready);
        o_valid          = r_out_valid;
        o_neighbor_index = r_out_index;
        o_last           = r_out_last;
        o_bad_index      = r_out_bad;
    end

    always_comb begin
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_oz        = r_oz;
        n_plane     = r_plane;
        n_nz        = r_nz;
        n_bad       = r_bad;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;
        n_out_valid = (r_out_valid && !i_ready) || emit;
        if (o_pop) begin
            n_plane = i_entry.plane;
            n_nz    = nz;
            n_bad   = i_entry.bad;
            n_i     = '0;
            n_j     = '0;
            n_k     = '0;
            if (i_entry.bad) begin
                // single result at index zero
                n_ox = '{crd: '0, cnt: OCNT_W'(1)};
                n_oy = '{crd: '0, cnt: OCNT_W'(1)};
                n_oz = '{crd: '0, cnt: OCNT_W'(1)};
            end else begin
                n_ox = offx;
                n_oy = offy;
                n_oz = offz;
            end
        end
        if (emit) begin
            n_out_index = sum[IDX_W-1:0];
            n_out_last  = last_one;
            n_out_bad   = r_bad;
            if (k_end) begin
                n_k = '0;
                if (j_end) begin
                    n_j = '0;
                    n_i = r_i + OCNT_W'(1);
                end else begin
                    n_j = r_j + OCNT_W'(1);
                end
            end else begin
                n_k = r_k + OCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ox        <= n_ox;
        r_oy        <= n_oy;
        r_oz        <= n_oz;
        r_plane     <= n_plane;
        r_nz        <= n_nz;
        r_bad       <= n_bad;
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
        r_out_bad   <= n_out_bad;
    end

endmodule
